FILE: src/assert_macros.svh
// Assertion macros shared by the checker files.
// No dependencies; the caller provides i_clk and i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Clocked assertion that also holds through reset.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

FILE: src/kvmt_pkg.sv
// Types, codes and default sizes for the key/value match table.
// No dependencies; imported by every module of the block.
package kvmt_pkg;

    localparam int unsigned ENTRIES_DEF    = 64;
    localparam int unsigned KEY_BITS_DEF   = 32;
    localparam int unsigned VALUE_BITS_DEF = 32;

    // Port field widths
    localparam int unsigned ACTION_W = 2;
    localparam int unsigned KEY_W    = 32;
    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned STATUS_W = 2;

    typedef enum logic [ACTION_W-1:0] {
        ACT_ADD    = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_EDIT   = 2'd2,
        ACT_SEARCH = 2'd3
    } t_action;

    // ST_CONFLICT: key present on add, key absent on everything else
    typedef enum logic [STATUS_W-1:0] {
        ST_DONE     = 2'd0,
        ST_CONFLICT = 2'd1,
        ST_FULL     = 2'd2,
        ST_ZERO_KEY = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        WR_NONE  = 2'd0,
        WR_ADD   = 2'd1,
        WR_CLEAR = 2'd2,
        WR_EDIT  = 2'd3
    } t_wr_op;

    // Control part of the lookup token walking the cell chain
    typedef struct packed {
        logic    valid;
        t_action action;
        logic    hit;
        logic    free_seen;
    } t_ctl;

endpackage

FILE: src/kvmt_cell.sv
// One table entry: stored key/value plus one stage of the lookup chain.
// Depends on kvmt_pkg.
module kvmt_cell import kvmt_pkg::*; #(
    parameter int unsigned IDX        = 0,
    parameter int unsigned KEY_BITS   = KEY_BITS_DEF,
    parameter int unsigned VALUE_BITS = VALUE_BITS_DEF,
    parameter int unsigned IDX_BITS   = 6
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // token from the previous cell
    input  t_ctl                  i_ctl,
    input  logic [KEY_BITS-1:0]   i_key,
    input  logic [VALUE_BITS-1:0] i_value,
    input  logic [IDX_BITS-1:0]   i_hit_idx,
    input  logic [VALUE_BITS-1:0] i_hit_value,
    input  logic [IDX_BITS-1:0]   i_free_idx,
    // token to the next cell
    output t_ctl                  o_ctl,
    output logic [KEY_BITS-1:0]   o_key,
    output logic [VALUE_BITS-1:0] o_value,
    output logic [IDX_BITS-1:0]   o_hit_idx,
    output logic [VALUE_BITS-1:0] o_hit_value,
    output logic [IDX_BITS-1:0]   o_free_idx,
    // write-back, broadcast to all cells
    input  t_wr_op                i_wr_op,
    input  logic [IDX_BITS-1:0]   i_wr_idx,
    input  logic [KEY_BITS-1:0]   i_wr_key,
    input  logic [VALUE_BITS-1:0] i_wr_value
);

    logic [KEY_BITS-1:0]   r_key;
    logic [KEY_BITS-1:0]   n_key;
    logic [VALUE_BITS-1:0] r_value;
    logic [VALUE_BITS-1:0] n_value;

    t_ctl                  r_ctl;
    t_ctl                  n_ctl;
    logic [KEY_BITS-1:0]   r_tok_key;
    logic [VALUE_BITS-1:0] r_tok_value;
    logic [IDX_BITS-1:0]   r_hit_idx;
    logic [IDX_BITS-1:0]   n_hit_idx;
    logic [VALUE_BITS-1:0] r_hit_value;
    logic [VALUE_BITS-1:0] n_hit_value;
    logic [IDX_BITS-1:0]   r_free_idx;
    logic [IDX_BITS-1:0]   n_free_idx;

    logic w_match;
    logic w_free;
    logic w_wr_sel;

    assign w_match  = i_ctl.valid && (r_key == i_key);
    assign w_free   = (r_key == '0);
    assign w_wr_sel = (i_wr_idx == IDX_BITS'(IDX));

    // first hit and first free entry win: later cells keep what came in
    always_comb begin
        n_ctl           = i_ctl;
        n_ctl.hit       = i_ctl.hit | w_match;
        n_ctl.free_seen = i_ctl.free_seen | w_free;
        n_hit_idx       = i_hit_idx;
        n_hit_value     = i_hit_value;
        n_free_idx      = i_free_idx;
        if (w_match && !i_ctl.hit) begin
            n_hit_idx   = IDX_BITS'(IDX);
            n_hit_value = r_value;
        end
        if (w_free && !i_ctl.free_seen) begin
            n_free_idx = IDX_BITS'(IDX);
        end
    end

    always_comb begin
        n_key   = r_key;
        n_value = r_value;
        if (w_wr_sel) begin
            unique case (i_wr_op)
                WR_ADD: begin
                    n_key   = i_wr_key;
                    n_value = i_wr_value;
                end
                WR_CLEAR: n_key   = '0;
                WR_EDIT:  n_value = i_wr_value;
                WR_NONE:  n_key   = r_key;
                default:  n_key   = r_key;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0;
            r_ctl <= '0;
        end else begin
            r_key <= n_key;
            r_ctl <= n_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value     <= n_value;
        r_tok_key   <= i_key;
        r_tok_value <= i_value;
        r_hit_idx   <= n_hit_idx;
        r_hit_value <= n_hit_value;
        r_free_idx  <= n_free_idx;
    end

    assign o_ctl       = r_ctl;
    assign o_key       = r_tok_key;
    assign o_value     = r_tok_value;
    assign o_hit_idx   = r_hit_idx;
    assign o_hit_value = r_hit_value;
    assign o_free_idx  = r_free_idx;

endmodule

FILE: src/key_value_match_table_unit.sv
// An accepted word's lookup token walks the cell chain through each entry's register in turn,
// and the result is registered at the output; a zero key is answered from the output register
// directly. No new word is taken until the token has left the last cell and written back.
// Reset (synchronous, active low) frees every entry at once; no clearing pass.
// Depends on kvmt_pkg and kvmt_cell.
module key_value_match_table_unit import kvmt_pkg::*; #(
    parameter int unsigned ENTRIES    = ENTRIES_DEF,
    parameter int unsigned KEY_BITS   = KEY_BITS_DEF,
    parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [KEY_W+VALUE_W-1:0] i_s_tdata,  // key, value
    input  logic [ACTION_W-1:0]    i_s_tuser,    // action
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [VALUE_W-1:0]     o_m_tdata,    // value_out
    output logic [STATUS_W-1:0]    o_m_tuser     // status
);

    localparam int unsigned IDX_BITS = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_WALK = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;

    // token chain, position g feeds cell g
    t_ctl                  c_ctl       [ENTRIES+1];
    logic [KEY_BITS-1:0]   c_key       [ENTRIES+1];
    logic [VALUE_BITS-1:0] c_value     [ENTRIES+1];
    logic [IDX_BITS-1:0]   c_hit_idx   [ENTRIES+1];
    logic [VALUE_BITS-1:0] c_hit_value [ENTRIES+1];
    logic [IDX_BITS-1:0]   c_free_idx  [ENTRIES+1];

    logic                  w_accept;
    logic [KEY_BITS-1:0]   w_in_key;
    logic [VALUE_BITS-1:0] w_in_value;
    logic                  w_key_zero;

    t_wr_op                w_wr_op;
    logic [IDX_BITS-1:0]   w_wr_idx;
    t_status               w_status;
    logic [VALUE_BITS-1:0] w_vout;

    logic                  r_out_valid;
    logic                  n_out_valid;
    t_status               r_status;
    t_status               n_status;
    logic [VALUE_W-1:0]    r_vout;
    logic [VALUE_W-1:0]    n_vout;

    assign o_s_tready = i_rst_n && (r_state == S_IDLE) && (!r_out_valid || i_m_tready);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_in_key   = KEY_BITS'(i_s_tdata[KEY_W-1:0]);
    assign w_in_value = VALUE_BITS'(i_s_tdata[KEY_W+VALUE_W-1:KEY_W]);
    assign w_key_zero = (w_in_key == '0);

    // valid, action, hit, free_seen
    assign c_ctl[0]       = {w_accept && !w_key_zero, t_action'(i_s_tuser), 1'b0, 1'b0};
    assign c_key[0]       = w_in_key;
    assign c_value[0]     = w_in_value;
    assign c_hit_idx[0]   = '0;
    assign c_hit_value[0] = '0;
    assign c_free_idx[0]  = '0;

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        kvmt_cell #(
            .IDX        (g),
            .KEY_BITS   (KEY_BITS),
            .VALUE_BITS (VALUE_BITS),
            .IDX_BITS   (IDX_BITS)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (c_ctl[g]),
            .i_key       (c_key[g]),
            .i_value     (c_value[g]),
            .i_hit_idx   (c_hit_idx[g]),
            .i_hit_value (c_hit_value[g]),
            .i_free_idx  (c_free_idx[g]),
            .o_ctl       (c_ctl[g+1]),
            .o_key       (c_key[g+1]),
            .o_value     (c_value[g+1]),
            .o_hit_idx   (c_hit_idx[g+1]),
            .o_hit_value (c_hit_value[g+1]),
            .o_free_idx  (c_free_idx[g+1]),
            .i_wr_op     (w_wr_op),
            .i_wr_idx    (w_wr_idx),
            .i_wr_key    (c_key[ENTRIES]),
            .i_wr_value  (c_value[ENTRIES])
        );
    end

    // token leaves the last cell: decide, write back, report
    always_comb begin
        w_wr_op  = WR_NONE;
        w_wr_idx = c_hit_idx[ENTRIES];
        w_status = ST_DONE;
        w_vout   = '0;
        if (c_ctl[ENTRIES].valid) begin
            unique case (c_ctl[ENTRIES].action)
                ACT_ADD: begin
                    if (c_ctl[ENTRIES].hit) begin
                        w_status = ST_CONFLICT;
                    end else if (!c_ctl[ENTRIES].free_seen) begin
                        w_status = ST_FULL;
                    end else begin
                        w_wr_op  = WR_ADD;
                        w_wr_idx = c_free_idx[ENTRIES];
                    end
                end
                ACT_REMOVE: begin
                    if (!c_ctl[ENTRIES].hit) begin
                        w_status = ST_CONFLICT;
                    end else begin
                        w_wr_op = WR_CLEAR;
                        w_vout  = c_hit_value[ENTRIES];
                    end
                end
                ACT_EDIT: begin
                    if (!c_ctl[ENTRIES].hit) begin
                        w_status = ST_CONFLICT;
                    end else begin
                        w_wr_op = WR_EDIT;
                    end
                end
                ACT_SEARCH: begin
                    if (!c_ctl[ENTRIES].hit) begin
                        w_status = ST_CONFLICT;
                    end else begin
                        w_vout = c_hit_value[ENTRIES];
                    end
                end
                default: w_status = ST_DONE;
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (w_accept && !w_key_zero) n_state = S_WALK;
            S_WALK: if (c_ctl[ENTRIES].valid) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // output slot is free whenever a word is accepted, so no collision here
    always_comb begin
        n_out_valid = r_out_valid;
        n_status    = r_status;
        n_vout      = r_vout;
        if (w_accept && w_key_zero) begin
            n_out_valid = 1'b1;
            n_status    = ST_ZERO_KEY;
            n_vout      = '0;
        end else if (c_ctl[ENTRIES].valid) begin
            n_out_valid = 1'b1;
            n_status    = w_status;
            n_vout      = VALUE_W'(w_vout);
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_vout   <= n_vout;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_vout;
    assign o_m_tuser  = r_status;

endmodule

FILE: src/kvmt_checker.sv
// Port-level checks for key_value_match_table_unit, bound to the top level.
// Depends on kvmt_pkg and assert_macros.svh.
`include "assert_macros.svh"

module kvmt_checker import kvmt_pkg::*; (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_s_tvalid,
    input logic                     o_s_tready,
    input logic [KEY_W+VALUE_W-1:0] i_s_tdata,  // key, value
    input logic                     o_m_tvalid,
    input logic                     i_m_tready,
    input logic [VALUE_W-1:0]       o_m_tdata,  // value_out
    input logic [STATUS_W-1:0]      o_m_tuser   // status
);

    logic                        w_in_take;
    logic                        w_in_zero;
    logic                        w_out_stall;
    logic                        w_out_fail;
    logic                        w_out_zero_reply;
    logic [STATUS_W+VALUE_W-1:0] w_out_word;

    assign w_in_take        = i_s_tvalid && o_s_tready;
    assign w_in_zero        = (i_s_tdata[KEY_W-1:0] == '0);
    assign w_out_stall      = o_m_tvalid && !i_m_tready;
    assign w_out_fail       = o_m_tvalid && (o_m_tuser != ST_DONE);
    assign w_out_zero_reply = o_m_tvalid && (o_m_tuser == ST_ZERO_KEY) && (o_m_tdata == '0);
    assign w_out_word       = {o_m_tuser, o_m_tdata};

    `ASSERT_CLK(a_out_hold, w_out_stall |=> o_m_tvalid && $stable(w_out_word), "word changed")
    `ASSERT_CLK(a_zero_key, w_in_take && w_in_zero |=> w_out_zero_reply, "zero key not refused")
    `ASSERT_CLK(a_no_accept_stalled, w_out_stall |-> !o_s_tready, "input taken under stall")
    `ASSERT_CLK(a_value_zero, w_out_fail |-> (o_m_tdata == '0), "value on failing status")

endmodule

bind key_value_match_table_unit kvmt_checker u_kvmt_checker (.*);
